// ===== rtl/core/i2cbm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cbm_pkg
// shared types and constants of the bit-level i2c master
// ----------------------------------------------------------------------------
package i2cbm_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] UNIT_TICKS_RESET = 8'd1;

  typedef enum logic [2:0] {
    MODE_START    = 3'd0,
    MODE_STOP     = 3'd1,
    MODE_WRITE    = 3'd2,
    MODE_READ     = 3'd3,
    MODE_SEND_ACK = 3'd4,
    MODE_RECV_ACK = 3'd5
  } mode_t;

  // one tick as classified by the front end
  typedef struct packed {
    logic       cmd_valid;
    logic       cmd_ok;
    logic [2:0] mode;
    logic [7:0] tx_byte;
    logic       ack_level;
    logic       sda_in;
  } tick_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] rx_byte;
    logic       ack_seen;
    logic       rejected;
  } result_t;

endpackage

// ===== rtl/core/i2c_bit_level_master.sv =====
// ----------------------------------------------------------------------------
// i2c_bit_level_master
// bit-level i2c bus master stepped by one tick per beat
// ----------------------------------------------------------------------------
// usage
//   input side is a queue: a tick beat is taken when push is high and full is
//   low; a tick may carry a command (start, stop, write, read, send ack,
//   receive ack) and carries the sampled sda level
//   result side is a queue: the oldest result sits on the ports while empty
//   is low and leaves on pop; every tick beat yields exactly one result beat
//   holding scl/sda levels, busy, done, the last read byte, ack and reject
//   unit_ticks is to be written through cfg_we/cfg_wdata only while idle,
//   which the block does not enforce; zero counts as one
// timing
//   one tick beat per cycle sustained while the result queue has room; a taken
//   tick is loaded into the tick queue, then the sequencer steps it into the
//   result queue when it is not full, and it shows on the ports once oldest
//   the sequencer step is a combinational decode, counter and line update
// reset
//   queues empty, lines released high, no sequence running, unit count one
// stalls
//   if pop stays low the result queue fills, then the tick queue, then full
//   rises; nothing is dropped and stepping resumes once pop returns
// ----------------------------------------------------------------------------
module i2c_bit_level_master #(
  parameter int QUEUE_DEPTH = i2cbm_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       push,
  output logic       full,
  input  logic       cmd_valid,
  input  logic [2:0] mode,
  input  logic [7:0] tx_byte,
  input  logic       ack_level,
  input  logic       sda_in,
  output logic       empty,
  input  logic       pop,
  output logic       scl_out,
  output logic       sda_out,
  output logic       busy_res,
  output logic       done_res,
  output logic [7:0] rx_byte,
  output logic       ack_seen,
  output logic       rejected
);

  i2cbm_pkg::tick_t   tick;
  logic               tick_empty;
  logic               tick_pop;
  i2cbm_pkg::result_t result;

  i2cbm_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .cmd_valid  (cmd_valid),
    .mode       (mode),
    .tx_byte    (tx_byte),
    .ack_level  (ack_level),
    .sda_in     (sda_in),
    .tick_pop   (tick_pop),
    .tick       (tick),
    .tick_empty (tick_empty)
  );

  i2cbm_seq #(
    .DEPTH (QUEUE_DEPTH)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .tick       (tick),
    .tick_empty (tick_empty),
    .tick_pop   (tick_pop),
    .pop        (pop),
    .result     (result),
    .empty      (empty)
  );

  assign scl_out  = result.scl;
  assign sda_out  = result.sda;
  assign busy_res = result.busy;
  assign done_res = result.done;
  assign rx_byte  = result.rx_byte;
  assign ack_seen = result.ack_seen;
  assign rejected = result.rejected;

endmodule

// ===== rtl/core/i2cbm_fifo.sv =====
// ----------------------------------------------------------------------------
// i2cbm_fifo
// small first-in first-out queue of packed entries
// ----------------------------------------------------------------------------
module i2cbm_fifo #(
  parameter int  DEPTH = i2cbm_pkg::QUEUE_DEPTH,
  parameter type entry_t = i2cbm_pkg::tick_t
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   wr_en,
  input  entry_t wr_data,
  output logic   full,
  input  logic   rd_en,
  output entry_t rd_data,
  output logic   empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             mem [DEPTH];
  logic   [PTR_W-1:0] wr_ptr;
  logic   [PTR_W-1:0] rd_ptr;
  logic   [CNT_W-1:0] count;
  logic               do_wr;
  logic               do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/i2cbm_front.sv =====
// ----------------------------------------------------------------------------
// i2cbm_front
// takes input ticks, flags unknown commands and queues them for the sequencer
// ----------------------------------------------------------------------------
module i2cbm_front #(
  parameter int DEPTH = i2cbm_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic              cmd_valid,
  input  logic [2:0]        mode,
  input  logic [7:0]        tx_byte,
  input  logic              ack_level,
  input  logic              sda_in,
  input  logic              tick_pop,
  output i2cbm_pkg::tick_t  tick,
  output logic              tick_empty
);

  i2cbm_pkg::tick_t classified;

  always_comb begin
    classified.cmd_valid = cmd_valid;
    classified.cmd_ok    = (mode <= 3'(i2cbm_pkg::MODE_RECV_ACK));
    classified.mode      = mode;
    classified.tx_byte   = tx_byte;
    classified.ack_level = ack_level;
    classified.sda_in    = sda_in;
  end

  i2cbm_fifo #(
    .DEPTH   (DEPTH),
    .entry_t (i2cbm_pkg::tick_t)
  ) u_tick_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (classified),
    .full    (full),
    .rd_en   (tick_pop),
    .rd_data (tick),
    .empty   (tick_empty)
  );

endmodule

// ===== rtl/core/i2cbm_seq.sv =====
// ----------------------------------------------------------------------------
// i2cbm_seq
// bus sequencer: one tick per cycle unless stalled; queues line levels, status
// ----------------------------------------------------------------------------
module i2cbm_seq #(
  parameter int DEPTH = i2cbm_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata,
  input  i2cbm_pkg::tick_t    tick,
  input  logic                tick_empty,
  output logic                tick_pop,
  input  logic                pop,
  output i2cbm_pkg::result_t  result,
  output logic                empty
);

  logic [7:0]       unit_ticks;
  i2cbm_pkg::mode_t cmd;
  logic [1:0]       phase;
  logic [3:0]       bit_idx;
  logic [9:0]       wait_cnt;
  logic [7:0]       shift;
  logic             scl;
  logic             sda;
  logic [7:0]       rx_q;
  logic             ack_q;

  i2cbm_pkg::mode_t cmd_next;
  logic [1:0]       phase_next;
  logic [3:0]       bit_idx_next;
  logic [9:0]       wait_cnt_next;
  logic [7:0]       shift_next;
  logic             scl_next;
  logic             sda_next;
  logic [7:0]       rx_q_next;
  logic             ack_q_next;

  logic               res_full;
  i2cbm_pkg::result_t res;

  assign tick_pop = !tick_empty && !res_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_ticks <= i2cbm_pkg::UNIT_TICKS_RESET;
    end else if (cfg_we) begin
      unit_ticks <= cfg_wdata;
    end
  end

  always_comb begin
    logic [7:0] unit_eff;
    logic [9:0] wait_dec;
    logic [1:0] last_phase;
    logic [1:0] units;
    logic       enter;
    logic       finish;

    cmd_next      = cmd;
    phase_next    = phase;
    bit_idx_next  = bit_idx;
    wait_cnt_next = wait_cnt;
    shift_next    = shift;
    scl_next      = scl;
    sda_next      = sda;
    rx_q_next     = rx_q;
    ack_q_next    = ack_q;
    res.done      = 1'b0;
    res.rejected  = 1'b0;
    enter         = 1'b0;
    finish        = 1'b0;
    units         = 2'd1;
    wait_dec      = (wait_cnt != '0) ? wait_cnt - 1'b1 : wait_cnt;
    unit_eff      = (unit_ticks == '0) ? 8'd1 : unit_ticks;
    last_phase    = (cmd == i2cbm_pkg::MODE_START || cmd == i2cbm_pkg::MODE_STOP ||
                     cmd == i2cbm_pkg::MODE_RECV_ACK) ? 2'd2 : 2'd3;

    if (phase == 2'd0) begin
      if (tick.cmd_valid) begin
        if (!tick.cmd_ok) begin
          res.rejected = 1'b1;
        end else begin
          cmd_next     = i2cbm_pkg::mode_t'(tick.mode);
          bit_idx_next = '0;
          if (cmd_next == i2cbm_pkg::MODE_WRITE) begin
            shift_next = tick.tx_byte;
          end else if (cmd_next == i2cbm_pkg::MODE_SEND_ACK) begin
            shift_next = {7'd0, tick.ack_level};
          end else begin
            shift_next = '0;
          end
          phase_next = 2'd1;
          enter      = 1'b1;
        end
      end
    end else begin
      res.rejected  = tick.cmd_valid;
      wait_cnt_next = wait_dec;
      if (wait_dec == '0) begin
        // sample lands on the tick that closes the scl-high phase
        if (cmd == i2cbm_pkg::MODE_READ && phase == 2'd2) begin
          shift_next = {shift[6:0], tick.sda_in};
        end
        if (cmd == i2cbm_pkg::MODE_RECV_ACK && phase == 2'd2) begin
          ack_q_next = ~tick.sda_in;
        end
        if (phase < last_phase) begin
          phase_next = phase + 2'd1;
          enter      = 1'b1;
        end else begin
          finish = 1'b1;
          if (cmd == i2cbm_pkg::MODE_WRITE || cmd == i2cbm_pkg::MODE_READ) begin
            bit_idx_next = bit_idx + 4'd1;
            if (bit_idx_next < 4'd8) begin
              phase_next = 2'd2;
              enter      = 1'b1;
              finish     = 1'b0;
            end
          end
        end
        if (finish) begin
          unique case (cmd)
            i2cbm_pkg::MODE_START: begin
              scl_next = 1'b0;
            end
            i2cbm_pkg::MODE_STOP: begin
              sda_next = 1'b1;
            end
            i2cbm_pkg::MODE_READ: begin
              rx_q_next = shift_next;
              scl_next  = 1'b0;
              sda_next  = 1'b1;
            end
            default: begin
              scl_next = 1'b0;
              sda_next = 1'b1;
            end
          endcase
          phase_next = 2'd0;
          res.done   = 1'b1;
        end
      end
    end

    // line levels and hold time of the phase being entered
    if (enter) begin
      unique case (cmd_next)
        i2cbm_pkg::MODE_START: begin
          if (phase_next == 2'd1) begin
            scl_next = 1'b1;
            sda_next = 1'b1;
          end else begin
            sda_next = 1'b0;
          end
          units = 2'd3;
        end
        i2cbm_pkg::MODE_STOP: begin
          if (phase_next == 2'd1) begin
            scl_next = 1'b0;
            sda_next = 1'b0;
          end else begin
            scl_next = 1'b1;
          end
          units = 2'd3;
        end
        i2cbm_pkg::MODE_WRITE: begin
          if (phase_next == 2'd1) begin
            scl_next = 1'b0;
            sda_next = 1'b0;
            units    = 2'd2;
          end else if (phase_next == 2'd2) begin
            scl_next = 1'b0;
            sda_next = shift_next[3'd7 - bit_idx_next[2:0]];
            units    = 2'd2;
          end else begin
            scl_next = 1'b1;
            units    = 2'd3;
          end
        end
        i2cbm_pkg::MODE_READ: begin
          if (phase_next == 2'd1) begin
            scl_next = 1'b0;
            sda_next = 1'b1;
            units    = 2'd3;
          end else if (phase_next == 2'd2) begin
            scl_next = 1'b1;
            units    = 2'd3;
          end else begin
            scl_next = 1'b0;
            units    = 2'd2;
          end
        end
        i2cbm_pkg::MODE_SEND_ACK: begin
          if (phase_next == 2'd1) begin
            scl_next = 1'b0;
            sda_next = 1'b0;
            units    = 2'd1;
          end else if (phase_next == 2'd2) begin
            sda_next = ~shift_next[0];
            units    = 2'd1;
          end else begin
            scl_next = 1'b1;
            units    = 2'd2;
          end
        end
        default: begin
          if (phase_next == 2'd1) begin
            scl_next = 1'b0;
            sda_next = 1'b1;
          end else begin
            scl_next = 1'b1;
          end
          units = 2'd1;
        end
      endcase
      unique case (units)
        2'd2:    wait_cnt_next = {1'b0, unit_eff, 1'b0};
        2'd3:    wait_cnt_next = {2'b00, unit_eff} + {1'b0, unit_eff, 1'b0};
        default: wait_cnt_next = {2'b00, unit_eff};
      endcase
    end

    res.scl      = scl_next;
    res.sda      = sda_next;
    res.busy     = (phase_next != 2'd0);
    res.rx_byte  = rx_q_next;
    res.ack_seen = ack_q_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd      <= i2cbm_pkg::MODE_START;
      phase    <= '0;
      bit_idx  <= '0;
      wait_cnt <= '0;
      shift    <= '0;
      scl      <= 1'b1;
      sda      <= 1'b1;
      rx_q     <= '0;
      ack_q    <= 1'b0;
    end else if (tick_pop) begin
      cmd      <= cmd_next;
      phase    <= phase_next;
      bit_idx  <= bit_idx_next;
      wait_cnt <= wait_cnt_next;
      shift    <= shift_next;
      scl      <= scl_next;
      sda      <= sda_next;
      rx_q     <= rx_q_next;
      ack_q    <= ack_q_next;
    end
  end

  i2cbm_fifo #(
    .DEPTH   (DEPTH),
    .entry_t (i2cbm_pkg::result_t)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (tick_pop),
    .wr_data (res),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (result),
    .empty   (empty)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the bit-level i2c master: every tick beat is
// mirrored by a tick-exact bus sequencer model in the bench, and each result
// beat is compared field by field against the oldest predicted line state;
// directed bus commands and unit settings come first, then random i2c
// transfers with stray commands, sender bursts and receiver stalls
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] MODE_BAD_A = 3'd6;
  localparam logic [2:0] MODE_BAD_B = 3'd7;

  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_ONE   = 4'd1;
  localparam logic [3:0] PH_TWO   = 4'd2;
  localparam logic [3:0] PH_THREE = 4'd3;

  localparam int SDA_LOW  = 0;
  localparam int SDA_HIGH = 1;
  localparam int SDA_RAND = 2;

  localparam int LONG_HOLD    = 60;
  localparam int MAX_SHOWN    = 10;
  localparam int RANDOM_TICKS = 100;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] mode;
    logic [7:0] tx_byte;
    logic       ack_level;
    logic       sda_in;
  } tick_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;
  logic       push = 1'b0;
  logic       cmd_valid = 1'b0;
  logic [2:0] mode = i2cbm_pkg::MODE_START;
  logic [7:0] tx_byte = 8'd0;
  logic       ack_level = 1'b0;
  logic       sda_in = 1'b1;
  logic       pop = 1'b0;
  logic       full;
  logic       empty;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_seen;
  logic       rejected;

  i2c_bit_level_master DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .push      (push),
    .full      (full),
    .cmd_valid (cmd_valid),
    .mode      (mode),
    .tx_byte   (tx_byte),
    .ack_level (ack_level),
    .sda_in    (sda_in),
    .empty     (empty),
    .pop       (pop),
    .scl_out   (scl_out),
    .sda_out   (sda_out),
    .busy_res  (busy_res),
    .done_res  (done_res),
    .rx_byte   (rx_byte),
    .ack_seen  (ack_seen),
    .rejected  (rejected)
  );

  always #1 clk = ~clk;

  // bus sequencer model state
  logic [7:0] unit_ticks = i2cbm_pkg::UNIT_TICKS_RESET;
  logic [2:0] seq_op     = i2cbm_pkg::MODE_START;
  logic [3:0] seq_step   = PH_IDLE;
  logic [3:0] bit_cnt    = 4'd0;
  logic [9:0] hold_cnt   = 10'd0;
  logic [7:0] shreg      = 8'd0;
  logic       line_scl   = 1'b1;
  logic       line_sda   = 1'b1;
  logic [7:0] last_rx    = 8'd0;
  logic       last_ack   = 1'b0;

  i2cbm_pkg::result_t line_states[$];
  int      bad_beats = 0;
  int      beats_seen = 0;
  int      ticks_sent = 0;

  // sender pacing
  int burst_left = 0;
  bit gaps_on = 1'b1;
  bit steady = 1'b0;

  // receiver pacing
  int       hold_ask = 0;
  int       hold_ack = 0;
  int       hold_left = 0;
  int       stall_style = 0;
  int       pat_cnt = 0;
  i2cbm_pkg::result_t got_beat;
  i2cbm_pkg::result_t want_beat;

  // set the lines of the current phase and load its hold time
  function automatic void load_step();
    int units;
    int per_unit;
    units = 1;
    case (seq_op)
      i2cbm_pkg::MODE_START: begin
        if (seq_step == PH_ONE) begin
          line_scl = 1'b1;
          line_sda = 1'b1;
        end else begin
          line_sda = 1'b0;
        end
        units = 3;
      end
      i2cbm_pkg::MODE_STOP: begin
        if (seq_step == PH_ONE) begin
          line_scl = 1'b0;
          line_sda = 1'b0;
        end else begin
          line_scl = 1'b1;
        end
        units = 3;
      end
      i2cbm_pkg::MODE_WRITE: begin
        if (seq_step == PH_ONE) begin
          line_scl = 1'b0;
          line_sda = 1'b0;
          units = 2;
        end else if (seq_step == PH_TWO) begin
          line_scl = 1'b0;
          line_sda = shreg[3'(7 - bit_cnt)];
          units = 2;
        end else begin
          line_scl = 1'b1;
          units = 3;
        end
      end
      i2cbm_pkg::MODE_READ: begin
        if (seq_step == PH_ONE) begin
          line_scl = 1'b0;
          line_sda = 1'b1;
          units = 3;
        end else if (seq_step == PH_TWO) begin
          line_scl = 1'b1;
          units = 3;
        end else begin
          line_scl = 1'b0;
          units = 2;
        end
      end
      i2cbm_pkg::MODE_SEND_ACK: begin
        if (seq_step == PH_ONE) begin
          line_scl = 1'b0;
          line_sda = 1'b0;
        end else if (seq_step == PH_TWO) begin
          line_sda = ~shreg[0];
        end else begin
          line_scl = 1'b1;
          units = 2;
        end
      end
      default: begin
        if (seq_step == PH_ONE) begin
          line_scl = 1'b0;
          line_sda = 1'b1;
        end else begin
          line_scl = 1'b1;
        end
      end
    endcase
    per_unit = (unit_ticks == 8'd0) ? 1 : int'(unit_ticks);
    hold_cnt = 10'(units * per_unit);
  endfunction

  // close the current phase, returns 1 when the whole sequence is over
  function automatic bit finish_step(input logic sda);
    logic [3:0] last_step;
    last_step = (seq_op == i2cbm_pkg::MODE_START || seq_op == i2cbm_pkg::MODE_STOP ||
                 seq_op == i2cbm_pkg::MODE_RECV_ACK) ? PH_TWO : PH_THREE;
    // sample while scl still stands high
    if (seq_op == i2cbm_pkg::MODE_READ && seq_step == PH_TWO) shreg = {shreg[6:0], sda};
    if (seq_op == i2cbm_pkg::MODE_RECV_ACK && seq_step == PH_TWO) last_ack = ~sda;
    if (seq_step < last_step) begin
      seq_step = seq_step + 4'd1;
      return 1'b0;
    end
    if (seq_op == i2cbm_pkg::MODE_WRITE || seq_op == i2cbm_pkg::MODE_READ) begin
      bit_cnt = bit_cnt + 4'd1;
      if (bit_cnt < 4'd8) begin
        seq_step = PH_TWO;
        return 1'b0;
      end
    end
    case (seq_op)
      i2cbm_pkg::MODE_START: line_scl = 1'b0;
      i2cbm_pkg::MODE_STOP: line_sda = 1'b1;
      i2cbm_pkg::MODE_READ: begin
        last_rx = shreg;
        line_scl = 1'b0;
        line_sda = 1'b1;
      end
      default: begin
        line_scl = 1'b0;
        line_sda = 1'b1;
      end
    endcase
    seq_step = PH_IDLE;
    return 1'b1;
  endfunction

  function automatic i2cbm_pkg::result_t bus_step(input tick_item_t item);
    i2cbm_pkg::result_t r;
    logic    fin;
    logic    rej;
    fin = 1'b0;
    rej = 1'b0;
    if (seq_step == PH_IDLE) begin
      if (item.cmd_valid) begin
        if (item.mode > i2cbm_pkg::MODE_RECV_ACK) begin
          rej = 1'b1;
        end else begin
          seq_op = item.mode;
          bit_cnt = 4'd0;
          if (item.mode == i2cbm_pkg::MODE_WRITE) shreg = item.tx_byte;
          else if (item.mode == i2cbm_pkg::MODE_SEND_ACK) shreg = {7'd0, item.ack_level};
          else shreg = 8'd0;
          seq_step = PH_ONE;
          load_step();
        end
      end
    end else begin
      // anything offered mid-sequence is dropped, closing tick included
      if (item.cmd_valid) rej = 1'b1;
      if (hold_cnt != 10'd0) hold_cnt = hold_cnt - 10'd1;
      if (hold_cnt == 10'd0) begin
        if (finish_step(item.sda_in)) fin = 1'b1;
        else load_step();
      end
    end
    r.scl = line_scl;
    r.sda = line_sda;
    r.busy = (seq_step != PH_IDLE);
    r.done = fin;
    r.rx_byte = last_rx;
    r.ack_seen = last_ack;
    r.rejected = rej;
    return r;
  endfunction

  function automatic void report_bad(input string what);
    bad_beats++;
    if (bad_beats <= MAX_SHOWN) $display("%t: %s", $realtime, what);
  endfunction

  // receiver: checks each popped beat, stalls on its own pattern
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        got_beat = '{scl: scl_out, sda: sda_out, busy: busy_res, done: done_res,
                     rx_byte: rx_byte, ack_seen: ack_seen, rejected: rejected};
        if (line_states.size() == 0) begin
          report_bad($sformatf("result beat %0d with nothing predicted", beats_seen));
        end else begin
          want_beat = line_states.pop_front();
          if (got_beat.scl !== want_beat.scl || got_beat.sda !== want_beat.sda ||
              got_beat.busy !== want_beat.busy || got_beat.done !== want_beat.done ||
              got_beat.rx_byte !== want_beat.rx_byte ||
              got_beat.ack_seen !== want_beat.ack_seen ||
              got_beat.rejected !== want_beat.rejected)
            report_bad($sformatf({"beat %0d: expected scl %0b sda %0b busy %0b done %0b ",
                                  "rx %02h ack %0b rej %0b, got scl %0b sda %0b busy %0b ",
                                  "done %0b rx %02h ack %0b rej %0b"}, beats_seen,
                                 want_beat.scl, want_beat.sda, want_beat.busy,
                                 want_beat.done, want_beat.rx_byte, want_beat.ack_seen,
                                 want_beat.rejected, got_beat.scl, got_beat.sda,
                                 got_beat.busy, got_beat.done, got_beat.rx_byte,
                                 got_beat.ack_seen, got_beat.rejected));
        end
        beats_seen++;
      end
      if (hold_ask != hold_ack) begin
        hold_ack <= hold_ask;
        hold_left <= LONG_HOLD;
        pop <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        pop <= 1'b0;
      end else begin
        pat_cnt <= pat_cnt + 1;
        if (pat_cnt % 48 == 0) stall_style <= $urandom_range(0, 3);
        case (stall_style)
          0: pop <= 1'b1;
          1: pop <= 1'($urandom_range(0, 1));
          2: pop <= (pat_cnt % 4 == 0);
          default: pop <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  task automatic push_tick(input tick_item_t item);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_on ? $urandom_range(1, 6) : 0;
      if ($urandom_range(0, 3) == 0) gaps_on = !gaps_on;
      if (gap > 0 && !steady) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    push <= 1'b1;
    cmd_valid <= item.cmd_valid;
    mode <= item.mode;
    tx_byte <= item.tx_byte;
    ack_level <= item.ack_level;
    sda_in <= item.sda_in;
    @(posedge clk);
    while (full) @(posedge clk);
    line_states.push_back(bus_step(item));
    ticks_sent++;
  endtask

  task automatic drain_results();
    push <= 1'b0;
    @(posedge clk);
    while (line_states.size() != 0) @(posedge clk);
  endtask

  task automatic write_unit(input logic [7:0] value);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    unit_ticks = value;
  endtask

  function automatic logic pick_sda(input int sel);
    if (sel == SDA_LOW) return 1'b0;
    if (sel == SDA_HIGH) return 1'b1;
    return 1'($urandom_range(0, 1));
  endfunction

  // stray command inside a running sequence now and then
  function automatic int stray_at();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 12) : -1;
  endfunction

  task automatic idle_ticks(input int n);
    tick_item_t item;
    repeat (n) begin
      item = tick_item_t'($urandom);
      item.cmd_valid = 1'b0;
      push_tick(item);
    end
  endtask

  // issue one command, then plain ticks until the sequence closes;
  // the tick numbered clash_at after the command carries another command
  task automatic run_cmd(input logic [2:0] op, input logic [7:0] data, input logic ackv,
                         input int sda_sel, input int clash_at);
    tick_item_t item;
    int         k;
    item.cmd_valid = 1'b1;
    item.mode = op;
    item.tx_byte = data;
    item.ack_level = ackv;
    item.sda_in = pick_sda(sda_sel);
    push_tick(item);
    k = 0;
    while (seq_step != PH_IDLE) begin
      item.cmd_valid = (k == clash_at);
      item.mode = 3'($urandom_range(0, 7));
      item.tx_byte = 8'($urandom);
      item.ack_level = 1'($urandom_range(0, 1));
      item.sda_in = pick_sda(sda_sel);
      push_tick(item);
      k++;
    end
  endtask

  task automatic bus_op(input logic [2:0] op);
    idle_ticks($urandom_range(0, 2));
    run_cmd(op, 8'($urandom), 1'($urandom_range(0, 1)), SDA_RAND, stray_at());
  endtask

  // start, address, ack, up to two data bytes each with its ack, stop
  task automatic random_transfer();
    int n;
    bus_op(i2cbm_pkg::MODE_START);
    bus_op(i2cbm_pkg::MODE_WRITE);
    bus_op(i2cbm_pkg::MODE_RECV_ACK);
    n = $urandom_range(0, 2);
    repeat (n) begin
      if ($urandom_range(0, 1) == 0) begin
        bus_op(i2cbm_pkg::MODE_WRITE);
        bus_op(i2cbm_pkg::MODE_RECV_ACK);
      end else begin
        bus_op(i2cbm_pkg::MODE_READ);
        bus_op(i2cbm_pkg::MODE_SEND_ACK);
      end
    end
    bus_op(i2cbm_pkg::MODE_STOP);
  endtask

  task automatic test_commands();
    tick_item_t item;
    // at one unit a start closes on the sixth tick after the command
    run_cmd(i2cbm_pkg::MODE_START, 8'h00, 1'b0, SDA_HIGH, 5);
    run_cmd(i2cbm_pkg::MODE_WRITE, 8'h00, 1'b0, SDA_LOW, -1);
    run_cmd(i2cbm_pkg::MODE_RECV_ACK, 8'hFF, 1'b1, SDA_LOW, -1);
    run_cmd(i2cbm_pkg::MODE_WRITE, 8'hFF, 1'b1, SDA_HIGH, 1);
    run_cmd(i2cbm_pkg::MODE_RECV_ACK, 8'h00, 1'b0, SDA_HIGH, -1);
    run_cmd(i2cbm_pkg::MODE_READ, 8'h5A, 1'b0, SDA_HIGH, -1);
    run_cmd(i2cbm_pkg::MODE_SEND_ACK, 8'h00, 1'b1, SDA_HIGH, -1);
    run_cmd(i2cbm_pkg::MODE_READ, 8'hA5, 1'b1, SDA_LOW, 7);
    run_cmd(i2cbm_pkg::MODE_SEND_ACK, 8'hFF, 1'b0, SDA_LOW, 0);
    run_cmd(i2cbm_pkg::MODE_READ, 8'h00, 1'b0, SDA_RAND, -1);
    // unknown modes are refused while idle
    item = '{cmd_valid: 1'b1, mode: MODE_BAD_A, tx_byte: 8'hFF, ack_level: 1'b1,
             sda_in: 1'b0};
    push_tick(item);
    item.mode = MODE_BAD_B;
    item.tx_byte = 8'h00;
    push_tick(item);
    run_cmd(i2cbm_pkg::MODE_STOP, 8'h00, 1'b0, SDA_RAND, 2);
    idle_ticks(3);
  endtask

  task automatic test_unit_extremes();
    write_unit(8'd0);
    run_cmd(i2cbm_pkg::MODE_WRITE, 8'hA5, 1'b0, SDA_RAND, -1);
    write_unit(8'd64);
    run_cmd(i2cbm_pkg::MODE_RECV_ACK, 8'h3C, 1'b1, SDA_LOW, 100);
    write_unit(8'd1);
    run_cmd(i2cbm_pkg::MODE_START, 8'h00, 1'b0, SDA_RAND, -1);
  endtask

  // long receiver hold while ticks keep coming, then a full drain
  task automatic test_backpressure();
    write_unit(8'd2);
    hold_ask <= hold_ask + 1;
    steady = 1'b1;
    run_cmd(i2cbm_pkg::MODE_READ, 8'h00, 1'b0, SDA_RAND, -1);
    steady = 1'b0;
    drain_results();
    run_cmd(i2cbm_pkg::MODE_STOP, 8'h00, 1'b0, SDA_RAND, -1);
  endtask

  task automatic test_random();
    int first_tick;
    first_tick = ticks_sent;
    while (ticks_sent - first_tick < RANDOM_TICKS) begin
      if ($urandom_range(0, 5) == 0) write_unit(8'($urandom_range(0, 4)));
      else write_unit(8'($urandom_range(1, 3)));
      if ($urandom_range(0, 4) != 0) begin
        random_transfer();
      end else begin
        repeat (3) bus_op(3'($urandom_range(0, 7)));
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_commands();
    test_unit_extremes();
    test_backpressure();
    test_random();
    drain_results();
    repeat (8) @(posedge clk);
    if (bad_beats == 0 && line_states.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/i2cbm_pkg.sv
rtl/core/i2cbm_fifo.sv
rtl/core/i2cbm_front.sv
rtl/core/i2cbm_seq.sv
rtl/core/i2c_bit_level_master.sv
tb/sv/tb_top.sv
